// ===== design/ttc_pkg.sv =====
`default_nettype none

package ttc_pkg;

  // Coordinate and datapath widths.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned NORM_W  = PROD_W + 2;
  localparam int unsigned HALF_W  = NORM_W / 2;
  localparam int unsigned MUL_W   = 2 * HALF_W;
  localparam int unsigned WIDE_W  = 2 * NORM_W + 3;

  // Result field widths.
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TOTAL_W = 16;

  // Default frame size and threshold after reset.
  localparam int unsigned POINTS_PER_FRAME_DEF = 22;
  localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(11);

  // Number of register stages in the angle test.
  localparam int unsigned SHARP_STAGES = 6;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // One frame memory slot holds the two stored frames of a point.
  typedef struct packed {
    point_t older;
    point_t middle;
  } slot_t;

  // Status of the angle test toward the controller.
  typedef struct packed {
    logic valid;
    logic hit;
  } sharp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // Difference of two coordinates with one guard bit.
  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

`default_nettype wire

// ===== design/ttc_frame_mem.sv =====
`default_nettype none

module ttc_frame_mem #(
  parameter int unsigned DEPTH  = ttc_pkg::POINTS_PER_FRAME_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rd_en_i,
  input  wire logic [ADDR_W-1:0]   rd_addr_i,
  output      ttc_pkg::slot_t      rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [ADDR_W-1:0]   wr_addr_i,
  input  wire ttc_pkg::slot_t      wr_data_i
);
  import ttc_pkg::*;

  slot_t mem_q [DEPTH];
  slot_t rd_data_q;

  // Synchronous write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Synchronous read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== design/ttc_sharp_unit.sv =====
`default_nettype none

module ttc_sharp_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire ttc_pkg::point_t     older_i,
  input  wire ttc_pkg::point_t     middle_i,
  input  wire ttc_pkg::point_t     new_i,
  output      ttc_pkg::sharp_res_t res_o
);
  import ttc_pkg::*;

  logic [SHARP_STAGES-1:0] vld_q;

  logic signed [DIFF_W-1:0] da_q [3];
  logic signed [DIFF_W-1:0] db_q [3];
  logic signed [PROD_W-1:0] dp_q [3];
  logic        [PROD_W-1:0] sqa_q [3];
  logic        [PROD_W-1:0] sqb_q [3];
  logic signed [SUM_W-1:0]  dot_q;
  logic        [NORM_W-1:0] na_q;
  logic        [NORM_W-1:0] nb_q;
  logic                     pos4_q;
  logic                     pos5_q;
  logic        [MUL_W-1:0]  d_hh_q, d_hl_q, d_ll_q;
  logic        [MUL_W-1:0]  n_hh_q, n_hl_q, n_lh_q, n_ll_q;
  logic        [WIDE_W-1:0] lhs_q;
  logic        [WIDE_W-1:0] rhs_q;
  logic                     hit_q;

  logic        [NORM_W-1:0] dmag;
  logic        [HALF_W-1:0] dh, dl, nah, nal, nbh, nbl;

  // One valid bit follows the request down the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SHARP_STAGES-2:0], start_i};
    end
  end

  // Stage one: vectors from the middle point to the older and new points.
  always_ff @(posedge clk_i) begin
    da_q[0] <= coord_diff(older_i.x, middle_i.x);
    da_q[1] <= coord_diff(older_i.y, middle_i.y);
    da_q[2] <= coord_diff(older_i.z, middle_i.z);
    db_q[0] <= coord_diff(new_i.x, middle_i.x);
    db_q[1] <= coord_diff(new_i.y, middle_i.y);
    db_q[2] <= coord_diff(new_i.z, middle_i.z);
  end

  // Stage two: per-axis products for the dot product and both norms.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      dp_q[k]  <= PROD_W'(da_q[k]) * PROD_W'(db_q[k]);
      sqa_q[k] <= $unsigned(PROD_W'(da_q[k]) * PROD_W'(da_q[k]));
      sqb_q[k] <= $unsigned(PROD_W'(db_q[k]) * PROD_W'(db_q[k]));
    end
  end

  // Stage three: sums over the three axes.
  always_ff @(posedge clk_i) begin
    dot_q <= SUM_W'(dp_q[0]) + SUM_W'(dp_q[1]) + SUM_W'(dp_q[2]);
    na_q  <= NORM_W'(sqa_q[0]) + NORM_W'(sqa_q[1]) + NORM_W'(sqa_q[2]);
    nb_q  <= NORM_W'(sqb_q[0]) + NORM_W'(sqb_q[1]) + NORM_W'(sqb_q[2]);
  end

  // Split the operands of the two wide squares into halves.
  assign dmag = NORM_W'($unsigned(dot_q));
  assign dh   = dmag[NORM_W-1:HALF_W];
  assign dl   = dmag[HALF_W-1:0];
  assign nah  = na_q[NORM_W-1:HALF_W];
  assign nal  = na_q[HALF_W-1:0];
  assign nbh  = nb_q[NORM_W-1:HALF_W];
  assign nbl  = nb_q[HALF_W-1:0];

  // Stage four: half-width partial products of dot^2 and |a|^2*|b|^2.
  always_ff @(posedge clk_i) begin
    pos4_q <= !dot_q[SUM_W-1] && (|dot_q);
    d_hh_q <= MUL_W'(dh) * MUL_W'(dh);
    d_hl_q <= MUL_W'(dh) * MUL_W'(dl);
    d_ll_q <= MUL_W'(dl) * MUL_W'(dl);
    n_hh_q <= MUL_W'(nah) * MUL_W'(nbh);
    n_hl_q <= MUL_W'(nah) * MUL_W'(nbl);
    n_lh_q <= MUL_W'(nal) * MUL_W'(nbh);
    n_ll_q <= MUL_W'(nal) * MUL_W'(nbl);
  end

  // Stage five: assemble 4*dot^2 and the norm product.
  always_ff @(posedge clk_i) begin
    pos5_q <= pos4_q;
    lhs_q  <= (WIDE_W'(d_hh_q) << (2 * HALF_W + 2))
            + (WIDE_W'(d_hl_q) << (HALF_W + 3))
            + (WIDE_W'(d_ll_q) << 2);
    rhs_q  <= (WIDE_W'(n_hh_q) << (2 * HALF_W))
            + ((WIDE_W'(n_hl_q) + WIDE_W'(n_lh_q)) << HALF_W)
            + WIDE_W'(n_ll_q);
  end

  // Stage six: the cosine exceeds one half only for a positive dot product.
  always_ff @(posedge clk_i) begin
    hit_q <= pos5_q && (lhs_q > rhs_q);
  end

  assign res_o.valid = vld_q[SHARP_STAGES-1];
  assign res_o.hit   = hit_q;

`ifndef SYNTHESIS
  a_single_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_q))
    else $error("more than one request in the angle pipeline");

  a_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (vld_q == '0))
    else $error("angle test started while busy");
`endif

endmodule

`default_nettype wire

// ===== design/trajectory_turn_counter_unit.sv =====
`default_nettype none

// Trajectory turn counter. Points arrive on the slave stream one request at a
// time, POINTS_PER_FRAME per frame, and each point is compared with the same
// slot of the two previous frames, which live in a frame memory that is read,
// updated and written back for every point. A point counts as sharp when the
// angle at the middle-frame point has a cosine above one half. After the last
// point of every frame from the third on, one result request carries the sharp
// count, the turn flag (count above the threshold) and the saturating turn
// total. One point is handled at a time: after acceptance a point passes through
// the memory read, the write-back and the six-stage angle test before the next
// point is accepted; the last point of a frame that produces a result also
// passes through the emit state, where it waits while the previous result is
// still waiting on the master stream. The threshold may be written only while
// the block is idle; it resets to 11.

module trajectory_turn_counter_unit #(
  parameter int unsigned POINTS_PER_FRAME = ttc_pkg::POINTS_PER_FRAME_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream tdata: pos_x [15:0], pos_y [31:16], pos_z [47:32].
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  // Master stream tdata: sharp_count [6:0], turn_flag [7], turn_total [23:8].
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,
  // Threshold register write port.
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i
);
  import ttc_pkg::*;

  localparam int unsigned IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_FRAME - 1);

  state_e state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [1:0]         frames_q, frames_d;
  logic [COUNT_W-1:0] running_q, running_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] thresh_q;
  point_t             pt_q;

  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_flag_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_load;
  logic               turn;

  logic       accept;
  logic       wr_en;
  slot_t      rd_slot;
  slot_t      wr_slot;
  sharp_res_t res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Frame memory: read the slot when the point is accepted, write back next cycle.
  assign wr_en          = (state_q == ST_START);
  assign wr_slot.older  = rd_slot.middle;
  assign wr_slot.middle = pt_q;

  ttc_frame_mem #(
    .DEPTH  (POINTS_PER_FRAME),
    .ADDR_W (IDX_W)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_slot),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_slot)
  );

  ttc_sharp_unit u_sharp_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wr_en),
    .older_i  (rd_slot.older),
    .middle_i (rd_slot.middle),
    .new_i    (pt_q),
    .res_o    (res)
  );

  // Capture the incoming point.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q.x <= s_axis_tdata[15:0];
      pt_q.y <= s_axis_tdata[31:16];
      pt_q.z <= s_axis_tdata[47:32];
    end
  end

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      frames_q    <= '0;
      running_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      frames_q    <= frames_d;
      running_q   <= running_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state, counters and result loading.
  assign turn = (running_q > thresh_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    frames_d    = frames_q;
    running_d   = running_q;
    total_d     = total_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (res.valid) begin
          if ((frames_q == 2'd2) && res.hit) begin
            running_d = running_q + COUNT_W'(1);
          end
          if (idx_q == LAST_IDX) begin
            idx_d = '0;
            if (frames_q != 2'd2) begin
              frames_d  = frames_q + 2'd1;
              running_d = '0;
              state_d   = ST_IDLE;
            end else begin
              state_d = ST_EMIT;
            end
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          running_d   = '0;
          if (turn && (total_q != '1)) begin
            total_d = total_q + TOTAL_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= running_q;
      out_flag_q  <= turn;
      out_total_q <= total_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_total_q, out_flag_q, out_count_q};

`ifndef SYNTHESIS
  a_result_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (state_q == ST_WAIT))
    else $error("angle result arrived outside the wait state");

  a_emit_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ((idx_q == '0) && (frames_q == 2'd2)))
    else $error("result pending away from a frame boundary");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == ST_START) && !s_axis_tready))
    else $error("accepted point did not start a memory update");

  a_frames_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q != 2'd3)
    else $error("frame counter passed its saturation value");
`endif

endmodule

`default_nettype wire

// ===== verif/ttc_turn_checker.sv =====
module ttc_turn_checker #(
  parameter int unsigned POINTS = ttc_pkg::POINTS_PER_FRAME_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Point requests: pos_x [15:0], pos_y [31:16], pos_z [47:32].
  input  wire logic        pt_valid_i,
  input  wire logic        pt_ready_i,
  input  wire logic [47:0] pt_data_i,
  // Frame results: sharp_count [6:0], turn_flag [7], turn_total [23:8].
  input  wire logic        res_valid_i,
  input  wire logic        res_ready_i,
  input  wire logic [23:0] res_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               flag;
    logic [COUNT_W-1:0] count;
  } frame_verdict_t;

  // Shadow copy of the two stored frames and the frame counters.
  point_t             older_pts [POINTS];
  point_t             middle_pts[POINTS];
  int unsigned        slot;
  int unsigned        frames_done;
  logic [COUNT_W-1:0] sharp_run;
  logic [COUNT_W-1:0] threshold;
  logic [TOTAL_W-1:0] turns;
  frame_verdict_t     verdicts_due[$];
  int                 miscompares;

  // The angle at the middle point is sharp when its cosine is above one half,
  // decided exactly as dot > 0 and 4*dot^2 > |a|^2 * |b|^2.
  function automatic bit angle_is_sharp(point_t o, point_t m, point_t n);
    longint       ax, ay, az, bx, by, bz;
    longint       dot, len_a, len_b;
    logic [127:0] dot_sq4, len_prod;
    ax = longint'($signed(o.x)) - longint'($signed(m.x));
    ay = longint'($signed(o.y)) - longint'($signed(m.y));
    az = longint'($signed(o.z)) - longint'($signed(m.z));
    bx = longint'($signed(n.x)) - longint'($signed(m.x));
    by = longint'($signed(n.y)) - longint'($signed(m.y));
    bz = longint'($signed(n.z)) - longint'($signed(m.z));
    dot   = ax * bx + ay * by + az * bz;
    len_a = ax * ax + ay * ay + az * az;
    len_b = bx * bx + by * by + bz * bz;
    if (dot <= 0) return 1'b0;
    dot_sq4  = 128'(dot) * 128'(dot);
    dot_sq4  = dot_sq4 << 2;
    len_prod = 128'(len_a) * 128'(len_b);
    return dot_sq4 > len_prod;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t         p;
    frame_verdict_t got, want;
    bit             flag;
    if (!rst_ni) begin
      slot        = 0;
      frames_done = 0;
      sharp_run   = '0;
      turns       = '0;
      threshold   = THRESH_RESET;
      miscompares = 0;
      verdicts_due.delete();
      for (int i = 0; i < POINTS; i++) begin
        older_pts[i]  = '0;
        middle_pts[i] = '0;
      end
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        threshold = cfg_wdata_i;
      end

      // Compare an accepted result request with the oldest expected verdict.
      if (res_valid_i && res_ready_i) begin
        got = res_data_i;
        if (verdicts_due.size() == 0) begin
          miscompares++;
          $display("%0t: unexpected result: count %0d flag %0d total %0d",
                   $time, got.count, got.flag, got.total);
        end else begin
          want = verdicts_due.pop_front();
          if (got.count !== want.count) begin
            miscompares++;
            $display("%0t: sharp_count expected %0d, got %0d", $time, want.count, got.count);
          end
          if (got.flag !== want.flag) begin
            miscompares++;
            $display("%0t: turn_flag expected %0d, got %0d", $time, want.flag, got.flag);
          end
          if (got.total !== want.total) begin
            miscompares++;
            $display("%0t: turn_total expected %0d, got %0d", $time, want.total, got.total);
          end
        end
      end

      // Advance the shadow state for an accepted point request.
      if (pt_valid_i && pt_ready_i) begin
        p = pt_data_i;
        if (frames_done >= 2 && angle_is_sharp(older_pts[slot], middle_pts[slot], p)) begin
          sharp_run = sharp_run + 1'b1;
        end
        older_pts[slot]  = middle_pts[slot];
        middle_pts[slot] = p;
        slot++;
        if (slot == POINTS) begin
          slot = 0;
          if (frames_done < 2) begin
            frames_done++;
          end else begin
            flag = sharp_run > threshold;
            if (flag && turns != '1) begin
              turns = turns + 1'b1;
            end
            want.count = sharp_run;
            want.flag  = flag;
            want.total = turns;
            verdicts_due.push_back(want);
          end
          sharp_run = '0;
        end
      end

      fail_count_o <= miscompares;
      pending_o    <= verdicts_due.size();
    end
  end

endmodule

// ===== verif/trajectory_turn_counter_unit_tb.sv =====
module trajectory_turn_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  localparam int unsigned POINTS        = POINTS_PER_FRAME_DEF;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_POINTS  = 212;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned TIMEOUT_NS    = 4_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        pt_valid  = 1'b0;
  logic        pt_ready;
  logic [47:0] pt_data   = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [23:0] res_data;
  logic        cfg_we    = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  int          fail_count;
  int          verdicts_pending;
  bit          no_idle   = 1'b0;

  // Last two frames sent, used only to shape the next point of each slot.
  point_t      hist_older [POINTS];
  point_t      hist_middle[POINTS];
  int unsigned gen_slot = 0;

  trajectory_turn_counter_unit #(
    .POINTS_PER_FRAME(POINTS)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(pt_valid),
    .s_axis_tready(pt_ready),
    .s_axis_tdata (pt_data),
    .m_axis_tvalid(res_valid),
    .m_axis_tready(res_ready),
    .m_axis_tdata (res_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  ttc_turn_checker #(
    .POINTS(POINTS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .pt_valid_i  (pt_valid),
    .pt_ready_i  (pt_ready),
    .pt_data_i   (pt_data),
    .res_valid_i (res_valid),
    .res_ready_i (res_ready),
    .res_data_i  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (verdicts_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[trajectory_turn_counter_unit] ERROR");
    $finish;
  end

  // The result side stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    res_ready <= no_idle || ($urandom_range(0, 99) >= 22);
  end

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic point_t pt(int x, int y, int z);
    point_t p;
    p.x = clamp16(x);
    p.y = clamp16(y);
    p.z = clamp16(z);
    return p;
  endfunction

  function automatic int jitter(int unsigned spread);
    return int'($urandom_range(0, 2 * spread)) - int'(spread);
  endfunction

  // Next point for the current slot: close to the older point (sharp),
  // mirrored through the middle point (obtuse), a repeat of the middle point,
  // or anything at all.
  function automatic point_t next_point(int unsigned sharp_pct);
    point_t      o, m, n;
    int unsigned pick, spread;
    o    = hist_older[gen_slot];
    m    = hist_middle[gen_slot];
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       spread = 0;
      1:       spread = 4;
      2:       spread = 400;
      default: spread = 6000;
    endcase
    if (pick < sharp_pct) begin
      n = pt(int'($signed(o.x)) + jitter(spread), int'($signed(o.y)) + jitter(spread),
             int'($signed(o.z)) + jitter(spread));
    end else if (pick < sharp_pct + (100 - sharp_pct) / 2) begin
      n = pt(2 * int'($signed(m.x)) - int'($signed(o.x)) + jitter(spread),
             2 * int'($signed(m.y)) - int'($signed(o.y)) + jitter(spread),
             2 * int'($signed(m.z)) - int'($signed(o.z)) + jitter(spread));
    end else if ($urandom_range(0, 9) == 0) begin
      n = m;
    end else begin
      n = {16'($urandom), 16'($urandom), 16'($urandom)};
    end
    return n;
  endfunction

  // Opening frames: the first slots carry hand-picked triples (older, middle,
  // new), the rest are random.
  function automatic point_t directed_point(int unsigned frame, int unsigned slot);
    case (slot)
      // Full-scale vectors pointing the same way.
      0: return (frame == 1) ? pt(32767, 32767, 32767) : pt(-32768, -32768, -32768);
      // Both vectors of zero length.
      1: return pt(4660, -4660, 291);
      // Older point equal to the middle point.
      2: return (frame == 2) ? pt(100, 200, 300) : pt(5, -7, 9);
      // Cosine exactly one half, which is not sharp.
      3: return (frame == 0) ? pt(1, 1, 0) : (frame == 1) ? pt(0, 0, 0) : pt(1, 0, 1);
      // Small vectors inside the sharp region.
      4: return (frame == 0) ? pt(11, 11, 11) : (frame == 1) ? pt(10, 10, 10) : pt(11, 11, 10);
      // Opposite directions.
      5: return (frame == 0) ? pt(100, -50, 25) : (frame == 1) ? pt(0, 0, 0) : pt(-100, 50, -25);
      // Perpendicular vectors.
      6: return (frame == 0) ? pt(7, 0, 0) : (frame == 1) ? pt(0, 0, 0) : pt(0, 7, 0);
      // Largest difference on every axis with mixed signs.
      7: return (frame == 1) ? pt(-32768, 32767, -32768) : pt(32767, -32768, 32767);
      default: return next_point($urandom_range(0, 100));
    endcase
  endfunction

  // Send one point request, with random idle cycles ahead of it.
  task automatic send_point(input point_t p);
    while (!no_idle && $urandom_range(0, 99) < 22) begin
      pt_valid <= 1'b0;
      @(posedge clk);
    end
    pt_valid <= 1'b1;
    pt_data  <= p;
    @(posedge clk);
    while (!pt_ready) @(posedge clk);
    hist_older[gen_slot]  = hist_middle[gen_slot];
    hist_middle[gen_slot] = p;
    gen_slot = (gen_slot + 1) % POINTS;
  endtask

  // The threshold changes only once every result is out and the last point
  // has had time to pass through the block.
  task automatic set_threshold(input logic [6:0] value);
    pt_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [6:0]  thresholds[PHASES];
    int unsigned sharp_pct;
    int unsigned waited;

    thresholds[0] = 7'd0;
    thresholds[1] = 7'd64;
    thresholds[2] = 7'($urandom_range(1, 20));
    thresholds[3] = 7'd127;
    thresholds[4] = 7'd11;
    thresholds[5] = 7'($urandom_range(0, 64));
    thresholds[6] = 7'($urandom_range(0, 22));
    sharp_pct = 50;
    for (int i = 0; i < POINTS; i++) begin
      hist_older[i]  = '0;
      hist_middle[i] = '0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset threshold.
    for (int unsigned f = 0; f < 3; f++) begin
      for (int unsigned s = 0; s < POINTS; s++) begin
        send_point(directed_point(f, s));
      end
    end

    // Random frames, one threshold per phase; one phase runs with no idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_threshold(thresholds[ph]);
      no_idle <= (ph == 3);
      repeat (PHASE_POINTS) begin
        if (gen_slot == 0) sharp_pct = $urandom_range(0, 100);
        send_point(next_point(sharp_pct));
      end
    end

    // Let the last results drain, then give the verdict.
    pt_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (verdicts_pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("[trajectory_turn_counter_unit] OK");
    end else begin
      $display("[trajectory_turn_counter_unit] ERROR");
    end
    $finish;
  end

endmodule
